/* rtl/core/tbrf_pkg.sv */
// Shared constants, register codes and types of the terrain raise brush.
package tbrf_pkg;

  // Fraction bits of coordinates and of the hardness fraction.
  localparam int CFB = 8;
  localparam int HFB = 16;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Divider shape: numerator, divisor and quotient widths.
  localparam int NUM_W = 58;
  localparam int DEN_W = 40;
  localparam int QUO_W = 34;

  typedef enum logic [CFG_AW-1:0] {
    REG_CENTRE_X,
    REG_CENTRE_Z,
    REG_ORIGIN_X,
    REG_ORIGIN_Z,
    REG_RADIUS,
    REG_HARDNESS,
    REG_CIRCULAR,
    REG_CHANGE
  } cfg_reg_e;

  // Per-vertex information that rides along the divider.
  typedef struct packed {
    logic signed [31:0] cur;
    logic               we;
    logic               circ;
    logic               core;
    logic               zero;
    logic               neg;
  } side_t;

endpackage

/* rtl/core/tbrf_if.sv */
// Valid/ready channel interfaces for vertices in and heights out.
interface tbrf_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic signed [31:0] current_height;

  modport source (output valid, output vertex_x, output vertex_y, output current_height,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input current_height,
                output ready);
endinterface

interface tbrf_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_height;
  logic               write_enable;

  modport source (output valid, output new_height, output write_enable, input ready);
  modport sink (input valid, input new_height, input write_enable, output ready);
endinterface

/* rtl/core/tbrf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module tbrf_div import tbrf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o,
  output side_t            side_o
);

  logic             v_q    [0:QUO_W];
  logic [DEN_W-1:0] rem_q  [0:QUO_W];
  logic [QUO_W-1:0] nq_q   [0:QUO_W];
  logic [DEN_W-1:0] den_q  [0:QUO_W];
  side_t            side_q [0:QUO_W];
  logic             ovf_q  [1:QUO_W];

  logic [DEN_W:0]   t_w    [QUO_W];
  logic             ge_w   [QUO_W];
  logic [DEN_W-1:0] rem_d  [QUO_W];
  logic [QUO_W-1:0] nq_d   [QUO_W];
  logic             ovf0;

  // Quotient would not fit: high part of numerator already reaches the divisor.
  assign ovf0 = rem_q[0] >= den_q[0];

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      t_w[k]   = {rem_q[k], nq_q[k][QUO_W-1]};
      ge_w[k]  = t_w[k] >= {1'b0, den_q[k]};
      rem_d[k] = ge_w[k] ? DEN_W'(t_w[k] - {1'b0, den_q[k]}) : DEN_W'(t_w[k]);
      nq_d[k]  = {nq_q[k][QUO_W-2:0], ge_w[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QUO_W; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 0; k < QUO_W; k++) v_q[k+1] <= v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DEN_W'(num_i[NUM_W-1:QUO_W]);
      nq_q[0]   <= num_i[QUO_W-1:0];
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      ovf_q[1]  <= ovf0;
      for (int k = 0; k < QUO_W; k++) begin
        rem_q[k+1]  <= rem_d[k];
        nq_q[k+1]   <= nq_d[k];
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
      for (int k = 1; k < QUO_W; k++) ovf_q[k+1] <= ovf_q[k];
    end
  end

  assign valid_o = v_q[QUO_W];
  assign quo_o   = nq_q[QUO_W];
  assign ovf_o   = ovf_q[QUO_W];
  assign side_o  = side_q[QUO_W];

endmodule

/* rtl/core/terrain_brush_raise_falloff_top.sv */
// Terrain raise brush with falloff: one heightmap vertex in, one height out.
//
//   channel   | direction | transfer when      | payload
//   in_vtx    | in        | valid & ready      | vertex_x, vertex_y, current_height
//   out_res   | out       | valid & ready      | new_height, write_enable
//   cfg       | in        | cfg_we_i           | cfg_addr_i, cfg_wdata_i
//
// Takes one vertex per clock while the output skid entry is empty.
// The path has 45 register stages: the input register, six arithmetic stages,
// the 35-register quotient pipeline, two delta stages and the output register.
// Reset clears all valid bits and loads the register defaults (circular mode on).
// An output register with a one-entry skid parts the sides; the pipeline holds only
// while the skid is full.
module terrain_brush_raise_falloff_top import tbrf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  tbrf_vtx_if.sink          in_vtx,
  tbrf_res_if.source        out_res
);

  localparam int RND_C = (1 << CFB) - 1;
  localparam int RND_H = (1 << HFB) - 1;

  // Configuration registers
  logic signed [23:0] cx_q, cz_q, ox_q, oz_q;
  logic        [19:0] rad_q;
  logic        [16:0] hard_q;
  logic               circ_q;
  logic signed [31:0] chg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cz_q   <= '0;
      ox_q   <= '0;
      oz_q   <= '0;
      rad_q  <= '0;
      hard_q <= '0;
      circ_q <= 1'b1;
      chg_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_CENTRE_X: cx_q   <= cfg_wdata_i[23:0];
        REG_CENTRE_Z: cz_q   <= cfg_wdata_i[23:0];
        REG_ORIGIN_X: ox_q   <= cfg_wdata_i[23:0];
        REG_ORIGIN_Z: oz_q   <= cfg_wdata_i[23:0];
        REG_RADIUS:   rad_q  <= cfg_wdata_i[19:0];
        REG_HARDNESS: hard_q <= cfg_wdata_i[16:0];
        REG_CIRCULAR: circ_q <= cfg_wdata_i[0];
        REG_CHANGE:   chg_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Round-toward-zero drop of the coordinate fraction.
  function automatic logic signed [16:0] trunc25(input logic signed [24:0] v);
    logic signed [24:0] t;
    t = v + (v[24] ? 25'(RND_C) : 25'sd0);
    return 17'(t >>> CFB);
  endfunction

  function automatic logic signed [17:0] trunc26(input logic signed [25:0] v);
    logic signed [25:0] t;
    t = v + (v[25] ? 26'(RND_C) : 26'sd0);
    return 18'(t >>> CFB);
  endfunction

  logic en;
  logic s_v_q;
  assign en           = !s_v_q;
  assign in_vtx.ready = en;

  // Stage A: input register
  logic               a_v_q;
  logic signed [15:0] a_tx_q, a_ty_q;
  logic signed [31:0] a_cur_q;

  // Stage B: centre and radius products
  logic               b_v_q;
  logic signed [15:0] b_tx_q, b_ty_q;
  logic signed [31:0] b_cur_q;
  logic signed [24:0] b_cx_q, b_cz_q;
  logic        [36:0] b_rh_q;
  logic        [39:0] b_rr_q;

  // Stage C: offsets and edges
  logic               c_v_q;
  logic signed [15:0] c_tx_q, c_ty_q;
  logic signed [31:0] c_cur_q;
  logic signed [16:0] c_icx_q, c_icz_q;
  logic signed [25:0] c_dx_q, c_dz_q;
  logic signed [25:0] c_cxl_q, c_cxh_q, c_czl_q, c_czh_q;
  logic signed [25:0] c_fxl_q, c_fxh_q, c_fzl_q, c_fzh_q;
  logic        [40:0] c_phi_q;
  logic        [35:0] c_plo_q;
  logic        [39:0] c_rr_q;

  // Stage D: squares, window, inner box
  logic               d_v_q;
  logic signed [15:0] d_tx_q, d_ty_q;
  logic signed [31:0] d_cur_q;
  logic        [50:0] d_dx2_q, d_dz2_q;
  logic        [41:0] d_i2_q;
  logic        [39:0] d_rr_q;
  logic               d_win_q;
  logic signed [17:0] d_ixl_q, d_ixh_q, d_izl_q, d_izh_q;
  logic signed [25:0] d_fxl_q, d_fxh_q, d_fzl_q, d_fzh_q;

  // Stage E: distance, ramp choice
  logic               e_v_q;
  logic signed [31:0] e_cur_q;
  logic               e_win_q;
  logic        [51:0] e_dist_q;
  logic        [41:0] e_i2_q;
  logic        [39:0] e_rr_q;
  logic               e_core_q;
  logic signed [15:0] e_f_q;
  logic signed [17:0] e_b_q;
  logic signed [25:0] e_e_q;

  // Stage F: ramp terms
  logic               f_v_q;
  logic signed [31:0] f_cur_q;
  logic               f_we_q, f_core_q;
  logic        [39:0] f_numc_q, f_denc_q;
  logic signed [26:0] f_d_q, f_dn_q;

  // Stage G: numerator product
  logic               g_v_q;
  logic signed [31:0] g_cur_q;
  logic               g_we_q, g_core_q;
  logic        [39:0] g_numc_q, g_denc_q;
  logic signed [26:0] g_d_q;
  logic signed [58:0] g_n_q;

  // ---- stage B logic
  logic signed [24:0] b_cx_d, b_cz_d;
  assign b_cx_d = 25'(cx_q) - 25'(ox_q);
  assign b_cz_d = 25'(cz_q) - 25'(oz_q);

  // ---- stage C logic
  logic [20:0] c_irad;
  logic [19:0] c_lq;
  assign c_irad = b_rh_q[36:16];
  assign c_lq   = {rad_q[19:CFB], CFB'(0)};

  // ---- stage D logic
  logic signed [51:0] d_dx2f, d_dz2f;
  logic signed [18:0] d_loop, d_xlo, d_xhi, d_zlo, d_zhi, d_tx19, d_tz19;
  assign d_dx2f = 52'(c_dx_q) * 52'(c_dx_q);
  assign d_dz2f = 52'(c_dz_q) * 52'(c_dz_q);
  assign d_loop = 19'($signed({1'b0, rad_q[19:CFB]}));
  assign d_xlo  = 19'(c_icx_q) - d_loop - 19'sd1;
  assign d_xhi  = 19'(c_icx_q) + d_loop + 19'sd1;
  assign d_zlo  = 19'(c_icz_q) - d_loop - 19'sd1;
  assign d_zhi  = 19'(c_icz_q) + d_loop + 19'sd1;
  assign d_tx19 = 19'(c_tx_q);
  assign d_tz19 = 19'(c_ty_q);

  // ---- stage E logic: pick the ramp (axis and side) for square falloff
  logic signed [18:0] ox_lo, ox_hi, oz_lo, oz_hi;
  logic               lt_x, gt_x, lt_z, gt_z, in_x, in_z;
  logic               e_core_d, use_x, use_max;
  logic signed [15:0] e_f_d;
  logic signed [17:0] e_b_d;
  logic signed [25:0] e_e_d;

  assign ox_lo = 19'(d_tx_q) - 19'(d_ixl_q);
  assign ox_hi = 19'(d_tx_q) - 19'(d_ixh_q);
  assign oz_lo = 19'(d_ty_q) - 19'(d_izl_q);
  assign oz_hi = 19'(d_ty_q) - 19'(d_izh_q);
  assign lt_x  = ox_lo < 19'sd0;
  assign gt_x  = ox_hi > 19'sd0;
  assign lt_z  = oz_lo < 19'sd0;
  assign gt_z  = oz_hi > 19'sd0;
  assign in_x  = !lt_x && !gt_x;
  assign in_z  = !lt_z && !gt_z;

  always_comb begin
    e_core_d = 1'b0;
    use_x    = 1'b1;
    use_max  = 1'b0;
    if (in_x && in_z) begin
      e_core_d = 1'b1;
    end else if (lt_x && in_z) begin
      use_x = 1'b1; use_max = 1'b0;
    end else if (gt_x && in_z) begin
      use_x = 1'b1; use_max = 1'b1;
    end else if (gt_z && in_x) begin
      use_x = 1'b0; use_max = 1'b1;
    end else if (lt_z && in_x) begin
      use_x = 1'b0; use_max = 1'b0;
    end else if (lt_x && gt_z) begin
      use_x   = ox_lo < -oz_hi;
      use_max = !use_x;
    end else if (gt_x && gt_z) begin
      use_x   = ox_hi > oz_hi;
      use_max = 1'b1;
    end else if (lt_x && lt_z) begin
      use_x   = ox_lo < oz_lo;
      use_max = 1'b0;
    end else begin
      use_x   = -ox_hi < oz_lo;
      use_max = use_x;
    end
    e_f_d = use_x ? d_tx_q : d_ty_q;
    if (use_x) begin
      e_b_d = use_max ? d_ixh_q : d_ixl_q;
      e_e_d = use_max ? d_fxh_q : d_fxl_q;
    end else begin
      e_b_d = use_max ? d_izh_q : d_izl_q;
      e_e_d = use_max ? d_fzh_q : d_fzl_q;
    end
  end

  // ---- stage F logic
  logic               f_inc, f_cramp;
  logic signed [25:0] f_bq;
  assign f_inc   = e_dist_q < 52'(e_rr_q);
  assign f_cramp = 52'(e_i2_q) < e_dist_q;
  assign f_bq    = 26'(e_b_q) <<< CFB;

  // ---- stage H logic: divider operands
  logic [NUM_W-1:0] h_absn, h_num;
  logic [26:0]      h_absd;
  logic [DEN_W-1:0] h_den;
  side_t            h_side;

  assign h_absn = g_n_q[58] ? NUM_W'(-g_n_q) : NUM_W'(g_n_q);
  assign h_absd = g_d_q[26] ? 27'(-g_d_q) : 27'(g_d_q);
  assign h_num  = circ_q ? NUM_W'({g_numc_q, HFB'(0)}) : h_absn;
  assign h_den  = circ_q ? g_denc_q : DEN_W'(h_absd);

  always_comb begin
    h_side.cur  = g_cur_q;
    h_side.we   = g_we_q;
    h_side.circ = circ_q;
    h_side.core = g_core_q;
    h_side.zero = !circ_q && (g_d_q == 27'sd0);
    h_side.neg  = g_n_q[58] ^ g_d_q[26];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_vtx.valid;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_tx_q  <= in_vtx.vertex_x;
      a_ty_q  <= in_vtx.vertex_y;
      a_cur_q <= in_vtx.current_height;

      b_tx_q  <= a_tx_q;
      b_ty_q  <= a_ty_q;
      b_cur_q <= a_cur_q;
      b_cx_q  <= b_cx_d;
      b_cz_q  <= b_cz_d;
      b_rh_q  <= 37'(rad_q) * 37'(hard_q);
      b_rr_q  <= 40'(rad_q) * 40'(rad_q);

      c_tx_q  <= b_tx_q;
      c_ty_q  <= b_ty_q;
      c_cur_q <= b_cur_q;
      c_icx_q <= trunc25(b_cx_q);
      c_icz_q <= trunc25(b_cz_q);
      c_dx_q  <= 26'(b_cx_q) - (26'(b_tx_q) <<< CFB);
      c_dz_q  <= 26'(b_cz_q) - (26'(b_ty_q) <<< CFB);
      c_cxl_q <= 26'(b_cx_q) - 26'($signed({1'b0, c_irad}));
      c_cxh_q <= 26'(b_cx_q) + 26'($signed({1'b0, c_irad}));
      c_czl_q <= 26'(b_cz_q) - 26'($signed({1'b0, c_irad}));
      c_czh_q <= 26'(b_cz_q) + 26'($signed({1'b0, c_irad}));
      c_fxl_q <= 26'(b_cx_q) - 26'($signed({1'b0, c_lq}));
      c_fxh_q <= 26'(b_cx_q) + 26'($signed({1'b0, c_lq}));
      c_fzl_q <= 26'(b_cz_q) - 26'($signed({1'b0, c_lq}));
      c_fzh_q <= 26'(b_cz_q) + 26'($signed({1'b0, c_lq}));
      c_phi_q <= 41'(rad_q) * 41'(c_irad);
      c_plo_q <= 36'(rad_q) * 36'(b_rh_q[15:0]);
      c_rr_q  <= b_rr_q;

      d_tx_q  <= c_tx_q;
      d_ty_q  <= c_ty_q;
      d_cur_q <= c_cur_q;
      d_dx2_q <= d_dx2f[50:0];
      d_dz2_q <= d_dz2f[50:0];
      d_i2_q  <= 42'(c_phi_q) + 42'(c_plo_q >> HFB);
      d_rr_q  <= c_rr_q;
      d_win_q <= (d_tx19 >= d_xlo) && (d_tx19 < d_xhi) &&
                 (d_tz19 >= d_zlo) && (d_tz19 < d_zhi);
      d_ixl_q <= trunc26(c_cxl_q);
      d_ixh_q <= trunc26(c_cxh_q);
      d_izl_q <= trunc26(c_czl_q);
      d_izh_q <= trunc26(c_czh_q);
      d_fxl_q <= c_fxl_q;
      d_fxh_q <= c_fxh_q;
      d_fzl_q <= c_fzl_q;
      d_fzh_q <= c_fzh_q;

      e_cur_q  <= d_cur_q;
      e_win_q  <= d_win_q;
      e_dist_q <= 52'(d_dx2_q) + 52'(d_dz2_q);
      e_i2_q   <= d_i2_q;
      e_rr_q   <= d_rr_q;
      e_core_q <= e_core_d;
      e_f_q    <= e_f_d;
      e_b_q    <= e_b_d;
      e_e_q    <= e_e_d;

      f_cur_q  <= e_cur_q;
      f_we_q   <= circ_q ? (e_win_q && f_inc) : e_win_q;
      f_core_q <= circ_q ? !f_cramp : e_core_q;
      f_numc_q <= 40'(52'(e_rr_q) - e_dist_q);
      f_denc_q <= 40'(42'(e_rr_q) - e_i2_q);
      f_d_q    <= 27'(e_e_q) - 27'(f_bq);
      f_dn_q   <= 27'(e_e_q) - (27'(e_f_q) <<< CFB);

      g_cur_q  <= f_cur_q;
      g_we_q   <= f_we_q;
      g_core_q <= f_core_q;
      g_numc_q <= f_numc_q;
      g_denc_q <= f_denc_q;
      g_d_q    <= f_d_q;
      g_n_q    <= 59'(f_dn_q) * 59'(chg_q);
    end
  end

  // Quotient pipeline
  logic             dv_v, dv_ovf;
  logic [QUO_W-1:0] dv_quo;
  side_t            dv_side;

  tbrf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_v_q),
    .num_i   (h_num),
    .den_i   (h_den),
    .side_i  (h_side),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side)
  );

  // Stage P1: weight product, saturated quotient
  logic               p_v_q;
  side_t              p_side_q;
  logic signed [48:0] p_prod_q;
  logic [QUO_W-1:0]   p_mag_q;
  logic [QUO_W-1:0]   p_mag_d;
  assign p_mag_d = dv_ovf ? '1 : dv_quo;

  // Stage P2: delta
  logic               q_v_q;
  logic signed [31:0] q_cur_q;
  logic               q_we_q;
  logic signed [35:0] q_delta_q;
  logic signed [48:0] q_prod_r;
  logic signed [35:0] q_delta_d, q_sd;

  always_comb begin
    q_prod_r = p_prod_q + (p_prod_q[48] ? 49'(RND_H) : 49'sd0);
    q_sd     = p_side_q.neg ? -36'($signed({2'b00, p_mag_q})) : 36'($signed({2'b00, p_mag_q}));
    if (p_side_q.core) begin
      q_delta_d = 36'(chg_q);
    end else if (p_side_q.circ) begin
      q_delta_d = 36'(q_prod_r >>> HFB);
    end else if (p_side_q.zero) begin
      q_delta_d = '0;
    end else begin
      q_delta_d = q_sd;
    end
    // drop a square-mode delta that points against the change
    if (!p_side_q.circ && (((chg_q > 32'sd0) && (q_delta_d < 36'sd0)) ||
                           ((chg_q < 32'sd0) && (q_delta_d > 36'sd0)))) begin
      q_delta_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      q_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= dv_v;
      q_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_side_q  <= dv_side;
      p_prod_q  <= 49'(chg_q) * 49'($signed({1'b0, p_mag_d[HFB-1:0]}));
      p_mag_q   <= p_mag_d;
      q_cur_q   <= p_side_q.cur;
      q_we_q    <= p_side_q.we;
      q_delta_q <= q_delta_d;
    end
  end

  // Final sum with saturation
  logic signed [36:0] r_sum;
  logic signed [31:0] r_height;
  always_comb begin
    r_sum = 37'(q_cur_q) + 37'(q_delta_q);
    if (r_sum > 37'sd2147483647) begin
      r_height = 32'sh7fffffff;
    end else if (r_sum < -37'sd2147483648) begin
      r_height = 32'sh80000000;
    end else begin
      r_height = 32'(r_sum);
    end
    if (!q_we_q) r_height = q_cur_q;
  end

  // Output register and skid entry
  logic               o_v_q, o_we_q, s_we_q, o_free;
  logic signed [31:0] o_h_q, s_h_q;
  assign o_free = !o_v_q || out_res.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
      s_v_q <= 1'b0;
    end else if (o_free) begin
      if (s_v_q) begin
        o_v_q <= 1'b1;
        s_v_q <= 1'b0;
      end else begin
        o_v_q <= q_v_q;
      end
    end else if (en && q_v_q) begin
      s_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_free) begin
      if (s_v_q) begin
        o_h_q  <= s_h_q;
        o_we_q <= s_we_q;
      end else begin
        o_h_q  <= r_height;
        o_we_q <= q_we_q;
      end
    end else if (en) begin
      s_h_q  <= r_height;
      s_we_q <= q_we_q;
    end
  end

  assign out_res.valid        = o_v_q;
  assign out_res.new_height   = o_h_q;
  assign out_res.write_enable = o_we_q;

endmodule

/* rtl/core/tbrf_chk.sv */
// Port-level checks of the terrain raise brush and their attachment to the top level.
module tbrf_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_new_height_i,
  input logic        out_write_enable_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_new_height_i) &&
                                    $stable(out_write_enable_i))
    else $error("result changed while stalled");

  // input stalls only with a result held at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled without a waiting result");

  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(out_valid_i && !out_ready_i))
    else $error("input stall began without an output stall");

  // skid drains as soon as the output moves
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i && out_ready_i |=> in_ready_i)
    else $error("input stall outlived the output stall");

endmodule

bind terrain_brush_raise_falloff_top tbrf_chk u_tbrf_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_i         (in_vtx.ready),
  .out_valid_i        (out_res.valid),
  .out_ready_i        (out_res.ready),
  .out_new_height_i   (out_res.new_height),
  .out_write_enable_i (out_res.write_enable)
);

/* tb/terrain_brush_raise_falloff_top_tb.sv */
// Self-checking testbench of the terrain raise brush: predicts heights and write flags.
module terrain_brush_raise_falloff_top_tb import tbrf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 44;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] new_height;
    logic               write_enable;
  } height_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;

  tbrf_vtx_if in_vtx ();
  tbrf_res_if out_res ();

  terrain_brush_raise_falloff_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_vtx     (in_vtx.sink),
    .out_res    (out_res.source)
  );

  // Shadow copy of the brush registers.
  logic signed [23:0] sh_centre_x = '0, sh_centre_z = '0, sh_origin_x = '0, sh_origin_z = '0;
  logic [19:0] sh_radius = '0;
  logic [16:0] sh_hardness = '0;
  logic        sh_circular = 1'b1;
  logic signed [31:0] sh_change = '0;

  height_t expected_heights[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  sender_bursty = 1'b1;
  bit  receiver_bursty = 1'b1;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    in_vtx.valid = 1'b0;
    in_vtx.vertex_x = '0;
    in_vtx.vertex_y = '0;
    in_vtx.current_height = '0;
    out_res.ready = 1'b0;
  end

  function automatic longint trunc_coord(longint v);
    if (v >= 0) return v >>> CFB;
    return -((-v) >>> CFB);
  endfunction

  function automatic longint ramp_delta(longint f, longint b, longint e, longint chg);
    longint bq, n, d;
    bq = b * (64'sd1 <<< CFB);
    n = f * (64'sd1 <<< CFB) - bq;
    d = e - bq;
    if (d == 0) return 0;
    return chg * (d - n) / d;
  endfunction

  function automatic height_t raise_height(logic signed [15:0] vx, logic signed [15:0] vy,
                                           logic signed [31:0] cur);
    longint cx, cy, r, loopr, icx, icy, h, chg, dx, dy, dsq, r2, i2, w, sum;
    longint irad, iminx, imaxx, iminy, imaxy, lq, fminx, fmaxx, fminy, fmaxy;
    longint tx, ty, one;
    bit we, inx, iny;
    height_t res;
    one = 64'sd1 <<< CFB;
    tx = vx;
    ty = vy;
    chg = sh_change;
    cx = longint'(sh_centre_x) - longint'(sh_origin_x);
    cy = longint'(sh_centre_z) - longint'(sh_origin_z);
    r = longint'(sh_radius);
    loopr = r >>> CFB;
    icx = trunc_coord(cx);
    icy = trunc_coord(cy);
    h = 0;
    we = 1'b0;
    if (tx >= icx - loopr - 1 && tx < icx + loopr + 1 &&
        ty >= icy - loopr - 1 && ty < icy + loopr + 1) begin
      if (sh_circular) begin
        dx = cx - tx * one;
        dy = cy - ty * one;
        dsq = dx * dx + dy * dy;
        r2 = r * r;
        i2 = longint'((64'(r2) * 64'(sh_hardness)) >> 16);
        if (dsq < r2) begin
          we = 1'b1;
          if (dsq > i2) begin
            w = longint'((64'(r2 - dsq) << 16) / 64'(r2 - i2));
            h = chg * w / 65536;
          end else begin
            h = chg;
          end
        end
      end else begin
        irad = longint'((64'(r) * 64'(sh_hardness)) >> 16);
        iminx = trunc_coord(cx - irad);
        imaxx = trunc_coord(cx + irad);
        iminy = trunc_coord(cy - irad);
        imaxy = trunc_coord(cy + irad);
        lq = loopr * one;
        fminx = cx - lq;
        fmaxx = cx + lq;
        fminy = cy - lq;
        fmaxy = cy + lq;
        inx = tx >= iminx && tx <= imaxx;
        iny = ty >= iminy && ty <= imaxy;
        we = 1'b1;
        if (inx && iny) h = chg;
        else if (tx < iminx && iny) h = ramp_delta(tx, iminx, fminx, chg);
        else if (tx > imaxx && iny) h = ramp_delta(tx, imaxx, fmaxx, chg);
        else if (ty > imaxy && inx) h = ramp_delta(ty, imaxy, fmaxy, chg);
        else if (ty < iminy && inx) h = ramp_delta(ty, iminy, fminy, chg);
        else if (tx < iminx && ty > imaxy)
          h = ((tx - iminx) < -(ty - imaxy)) ? ramp_delta(tx, iminx, fminx, chg)
                                             : ramp_delta(ty, imaxy, fmaxy, chg);
        else if (tx > imaxx && ty > imaxy)
          h = ((tx - imaxx) > (ty - imaxy)) ? ramp_delta(tx, imaxx, fmaxx, chg)
                                            : ramp_delta(ty, imaxy, fmaxy, chg);
        else if (tx < iminx && ty < iminy)
          h = ((tx - iminx) < (ty - iminy)) ? ramp_delta(tx, iminx, fminx, chg)
                                            : ramp_delta(ty, iminy, fminy, chg);
        else if (tx > imaxx && ty < iminy)
          h = (-(tx - imaxx) < (ty - iminy)) ? ramp_delta(tx, imaxx, fmaxx, chg)
                                             : ramp_delta(ty, iminy, fminy, chg);
        // Clamp a delta of opposite sign to zero.
        if ((chg > 0 && h < 0) || (chg < 0 && h > 0)) h = 0;
      end
    end
    sum = longint'(cur) + h;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    if (!we) sum = cur;
    res.new_height = sum[31:0];
    res.write_enable = we;
    return res;
  endfunction

  // Receiver: random ready bursts, check each transfer against the oldest prediction.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (receiver_bursty && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 19);
        out_res.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_res.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (in_vtx.valid && in_vtx.ready) begin
      expected_heights.push_back(raise_height(in_vtx.vertex_x, in_vtx.vertex_y,
                                              in_vtx.current_height));
    end
    if (out_res.valid && out_res.ready) begin
      if (expected_heights.size() == 0) begin
        $error("result transfer with no prediction waiting");
        mismatches++;
      end else begin
        height_t e;
        e = expected_heights.pop_front();
        if (out_res.new_height !== e.new_height) begin
          $error("new_height expected %0d actual %0d", e.new_height, out_res.new_height);
          mismatches++;
        end
        if (out_res.write_enable !== e.write_enable) begin
          $error("write_enable expected %0d actual %0d", e.write_enable,
                 out_res.write_enable);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_vtx.valid && in_vtx.ready) || (out_res.valid && out_res.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL terrain_brush_raise_falloff_top");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CENTRE_X: sh_centre_x = value[23:0];
      REG_CENTRE_Z: sh_centre_z = value[23:0];
      REG_ORIGIN_X: sh_origin_x = value[23:0];
      REG_ORIGIN_Z: sh_origin_z = value[23:0];
      REG_RADIUS:   sh_radius = value[19:0];
      REG_HARDNESS: sh_hardness = value[16:0];
      REG_CIRCULAR: sh_circular = value[0];
      REG_CHANGE:   sh_change = value[31:0];
      default: ;
    endcase
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic drain_results();
    in_vtx.valid <= 1'b0;
    while (expected_heights.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic setup_brush(logic signed [23:0] cxv, logic signed [23:0] czv,
                             logic signed [23:0] oxv, logic signed [23:0] ozv,
                             logic [19:0] rad, logic [16:0] hard, bit circ,
                             logic signed [31:0] chg);
    drain_results();
    write_reg(REG_CENTRE_X, 32'(cxv));
    write_reg(REG_CENTRE_Z, 32'(czv));
    write_reg(REG_ORIGIN_X, 32'(oxv));
    write_reg(REG_ORIGIN_Z, 32'(ozv));
    write_reg(REG_RADIUS, 32'(rad));
    write_reg(REG_HARDNESS, 32'(hard));
    write_reg(REG_CIRCULAR, 32'(circ));
    write_reg(REG_CHANGE, 32'(chg));
  endtask

  // Drive one vertex and hold it until the transfer; valid stays high for the next one.
  task automatic send_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                             logic signed [31:0] cur);
    if (sender_bursty && $urandom_range(0, 7) == 0) begin
      in_vtx.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_vtx.valid <= 1'b1;
    in_vtx.vertex_x <= vx;
    in_vtx.vertex_y <= vy;
    in_vtx.current_height <= cur;
    @(posedge clk_i);
    while (!in_vtx.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_height();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // Vertex drawn around the brush window; one in ten is drawn anywhere.
  task automatic send_near(int span);
    longint cx, cy, lr;
    cx = trunc_coord(longint'(sh_centre_x) - longint'(sh_origin_x));
    cy = trunc_coord(longint'(sh_centre_z) - longint'(sh_origin_z));
    lr = (sh_radius >> CFB) + 2;
    if ($urandom_range(0, 9) == 0)
      send_vertex(16'($urandom), 16'($urandom), rand_height());
    else
      send_vertex(16'(cx + $signed($urandom_range(0, 2 * (lr + span))) - lr - span),
                  16'(cy + $signed($urandom_range(0, 2 * (lr + span))) - lr - span),
                  rand_height());
  endtask

  task automatic test_reset_defaults();
    send_vertex(16'sd0, 16'sd0, 32'sd100);
    send_vertex(-16'sd1, -16'sd1, 32'sh80000000);
    send_vertex(16'sh7fff, 16'sh8000, 32'sh7fffffff);
  endtask

  task automatic test_directed_extremes();
    setup_brush(24'sh000480, 24'sh000380, 24'sd0, 24'sd0, 20'h00500, 17'h08000, 1'b1,
                32'sh00010000);
    for (int i = 0; i < 5; i++) send_vertex(16'(i + 2), 16'sd3, 32'sh7fffff00);
    setup_brush(24'sh000480, 24'sh000380, 24'sd0, 24'sd0, 20'h00500, 17'h08000, 1'b0,
                -32'sh00030000);
    for (int i = 0; i < 5; i++) send_vertex(16'(i), 16'(i + 1), 32'sh80000100);
    // Full hardness and zero radius at extreme centre and origin values.
    setup_brush(24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff, 20'h0, 17'h10000,
                1'b0, 32'sh7fffffff);
    send_vertex(16'sd0, 16'sd0, 32'sd5);
    send_vertex(16'sh7fff, 16'sh8000, 32'sd5);
    setup_brush(-24'sh000140, 24'sh0001c0, 24'sd0, 24'sd0, 20'h00300, 17'h1ffff, 1'b0,
                32'sh80000000);
    for (int i = -4; i < 4; i++) send_vertex(16'(i), 16'(i), $urandom);
    setup_brush(24'sd0, 24'sd0, 24'sd0, 24'sd0, 20'hfffff, 17'h0, 1'b1, 32'sh7fffffff);
    send_vertex(16'sh7fff, 16'sh7fff, 32'sd0);
    send_vertex(16'sh8000, 16'sh8000, 32'sd1);
  endtask

  task automatic test_random_brushes(int phases, int per_phase);
    logic [19:0] rad;
    for (int p = 0; p < phases; p++) begin
      rad = ($urandom_range(0, 15) == 0) ? 20'($urandom) : 20'($urandom_range(0, 2600));
      setup_brush(24'($urandom), 24'($urandom),
                  $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'sd0,
                  $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'sd0, rad,
                  17'($urandom_range(0, 65536 + ($urandom_range(0, 4) == 0 ? 65535 : 0))),
                  $urandom_range(0, 1), $urandom);
      for (int i = 0; i < per_phase; i++) send_near(2);
      // Let the pipeline empty with no new vertices.
      if (p == 2) begin
        in_vtx.valid <= 1'b0;
        while (expected_heights.size() != 0) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_directed_extremes();
    test_random_brushes(30, 38);
    sender_bursty = 1'b0;
    receiver_bursty = 1'b0;
    test_random_brushes(5, 40);
    drain_results();
    if (mismatches == 0) $display("PASS terrain_brush_raise_falloff_top");
    else $display("FAIL terrain_brush_raise_falloff_top");
    $finish;
  end

endmodule
